// ----- src/pta_pkg.sv -----
// ----------------------------------------------------------------------------
// pta_pkg: shared types and constants for the peer table with aging
// Holds the payload structs, request and status codes, the controller
// state enum and the command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package pta_pkg;

	localparam int PeerSlots = 8;
	localparam int SlotW     = (PeerSlots > 1) ? $clog2(PeerSlots) : 1;
	localparam int CntW      = $clog2(PeerSlots + 1);

	typedef enum logic [1:0] {
		REQ_BEACON = 2'd0,
		REQ_TICK   = 2'd1,
		REQ_READ   = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_BAD     = 3'd0,
		ST_OWN     = 3'd1,
		ST_REFRESH = 3'd2,
		ST_INSERT  = 3'd3,
		ST_EVICT   = 3'd4,
		ST_NOSLOT  = 3'd5,
		ST_TICK    = 3'd6,
		ST_READ    = 3'd7
	} status_t;

	typedef enum logic [2:0] {
		REG_OWN_IP    = 3'd0,
		REG_MAGIC     = 3'd1,
		REG_MIN_LEN   = 3'd2,
		REG_TTL       = 3'd3,
		REG_PERIOD    = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_WRITE,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] now_ms;
		logic [47:0] peer_mac;
		logic [31:0] beacon_ip;
		logic [31:0] magic_word;
		logic [7:0]  beacon_version;
		logic [7:0]  frame_len;
		logic [5:0]  slot_index;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [5:0]  slot;
		logic [6:0]  peer_count;
		logic        send_beacon;
		logic [6:0]  expired_count;
		logic        entry_valid;
		logic [47:0] entry_mac;
		logic [31:0] entry_ip;
		logic [31:0] entry_age;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture input item, start new item
		logic scan;      // examine slot at scan pointer
		logic commit;    // apply beacon/tick update
		logic out_load;  // form result into output register
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_last; // scan pointer at final slot
		logic needs_scan; // item is beacon passing checks or tick
		logic needs_write; // beacon passing checks
	} dp_sts_t;

endpackage
`default_nettype wire

// ----- src/pta_ctrl.sv -----
// ----------------------------------------------------------------------------
// pta_ctrl: controller for the peer table
// Sequences capture, slot scan, update and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none
module pta_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output pta_pkg::dp_cmd_t      cmd,
	input  wire pta_pkg::dp_sts_t sts
);

	pta_pkg::state_t state_q, state_nx;
	logic out_valid_q, out_valid_nx;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pta_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nx;
			out_valid_q <= out_valid_nx;
		end
	end

	// next state and commands
	always_comb begin
		state_nx     = state_q;
		out_valid_nx = out_valid_q;
		cmd          = '0;
		in_ready     = 1'b0;
		if (out_valid_q && out_ready) out_valid_nx = 1'b0;
		case (state_q)
			pta_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = pta_pkg::S_SCAN;
				end
			end
			pta_pkg::S_SCAN: begin
				if (!sts.needs_scan) begin
					state_nx = pta_pkg::S_OUT;
				end else begin
					cmd.scan = 1'b1;
					if (sts.scan_last) state_nx = pta_pkg::S_WRITE;
				end
			end
			pta_pkg::S_WRITE: begin
				cmd.commit = 1'b1;
				state_nx   = pta_pkg::S_OUT;
			end
			pta_pkg::S_OUT: begin
				// wait for the output register to free
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					out_valid_nx = 1'b1;
					state_nx     = pta_pkg::S_IDLE;
				end
			end
			default: state_nx = pta_pkg::S_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// ----- src/pta_dp.sv -----
// ----------------------------------------------------------------------------
// pta_dp: datapath for the peer table
// Slot storage, configuration registers, serial slot scan and result forming.
// ----------------------------------------------------------------------------
`default_nettype none
module pta_dp (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	input  wire logic [2:0]        cfg_index,
	input  wire logic [31:0]       cfg_data,
	input  wire pta_pkg::in_item_t in_item,
	input  wire pta_pkg::dp_cmd_t  cmd,
	output pta_pkg::dp_sts_t       sts,
	output pta_pkg::out_item_t     out_item
);

	localparam int N  = pta_pkg::PeerSlots;
	localparam int SW = pta_pkg::SlotW;
	localparam int CW = pta_pkg::CntW;

	// configuration
	logic [31:0] own_ip_q, magic_q, ttl_q, period_q;
	logic [7:0]  min_len_q;

	// slot store
	logic [N-1:0] valid_q;
	logic [47:0]  mac_q  [N];
	logic [31:0]  ip_q   [N];
	logic [31:0]  seen_q [N];
	logic [CW-1:0] count_q;
	logic [31:0]  last_beacon_q;

	// captured item and scan state
	pta_pkg::in_item_t item_q;
	logic [SW-1:0] ptr_q;
	logic          hit_q, free_q;
	logic [SW-1:0] hit_idx_q, free_idx_q, lru_idx_q;
	logic [31:0]   lru_seen_q;
	logic [N-1:0]  expire_q;
	logic          frame_ok, not_own, is_beacon, is_tick;

	assign is_beacon = (item_q.req_type == pta_pkg::REQ_BEACON);
	assign is_tick   = (item_q.req_type == pta_pkg::REQ_TICK);
	assign frame_ok  = (item_q.frame_len >= min_len_q) && (item_q.magic_word == magic_q)
		&& (item_q.beacon_version == 8'd1);
	assign not_own   = (item_q.beacon_ip != own_ip_q);

	assign sts.needs_write = is_beacon && frame_ok && not_own;
	assign sts.needs_scan  = sts.needs_write || is_tick;
	assign sts.scan_last   = (ptr_q == SW'(N - 1));

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q  <= '0;
			magic_q   <= '0;
			min_len_q <= '0;
			ttl_q     <= '0;
			period_q  <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				pta_pkg::REG_OWN_IP:  own_ip_q  <= cfg_data;
				pta_pkg::REG_MAGIC:   magic_q   <= cfg_data;
				pta_pkg::REG_MIN_LEN: min_len_q <= cfg_data[7:0];
				pta_pkg::REG_TTL:     ttl_q     <= cfg_data;
				pta_pkg::REG_PERIOD:  period_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// one slot per cycle: match, first free, oldest, expiry
	logic [31:0] age_cur;
	assign age_cur = item_q.now_ms - seen_q[ptr_q];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q     <= in_item;
			ptr_q      <= '0;
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
			hit_idx_q  <= '0;
			free_idx_q <= '0;
			lru_idx_q  <= '0;
			lru_seen_q <= '1;
			expire_q   <= '0;
		end else if (cmd.scan) begin
			ptr_q <= (ptr_q == SW'(N - 1)) ? '0 : ptr_q + SW'(1);
			if (valid_q[ptr_q] && mac_q[ptr_q] == item_q.peer_mac && !hit_q) begin
				hit_q     <= 1'b1;
				hit_idx_q <= ptr_q;
			end
			if (!valid_q[ptr_q] && !free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= ptr_q;
			end
			// strict less keeps lowest index on ties; slot 0 always taken
			if (ptr_q == '0 || seen_q[ptr_q] < lru_seen_q) begin
				lru_seen_q <= seen_q[ptr_q];
				lru_idx_q  <= ptr_q;
			end
			expire_q[ptr_q] <= valid_q[ptr_q] && (age_cur > ttl_q);
		end
	end

	// beacon target and status
	logic [SW-1:0]     tgt;
	pta_pkg::status_t  bstat;
	always_comb begin
		if (hit_q) begin
			tgt = hit_idx_q; bstat = pta_pkg::ST_REFRESH;
		end else if (free_q) begin
			tgt = free_idx_q; bstat = pta_pkg::ST_INSERT;
		end else begin
			tgt = lru_idx_q; bstat = pta_pkg::ST_EVICT;
		end
	end

	logic [N-1:0] valid_nx;
	logic [CW-1:0] cnt_nx;
	always_comb begin
		valid_nx = valid_q;
		if (is_tick) valid_nx = valid_q & ~expire_q;
		else         valid_nx[tgt] = 1'b1;
		cnt_nx = '0;
		for (int i = 0; i < N; i++) cnt_nx = cnt_nx + CW'(valid_nx[i]);
	end

	logic send_q;

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q       <= '0;
			count_q       <= '0;
			last_beacon_q <= '0;
			send_q        <= 1'b0;
		end else begin
			if (cmd.load) send_q <= 1'b0;
			if (cmd.commit) begin
				valid_q <= valid_nx;
				count_q <= cnt_nx;
				if (is_tick && (item_q.now_ms - last_beacon_q) >= period_q) begin
					send_q        <= 1'b1;
					last_beacon_q <= item_q.now_ms;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && !is_tick) begin
			mac_q[tgt]  <= item_q.peer_mac;
			ip_q[tgt]   <= item_q.beacon_ip;
			seen_q[tgt] <= item_q.now_ms;
		end
	end

	// read-slot lookup
	logic          rd_ok;
	logic [SW-1:0] rd_idx;
	assign rd_idx = item_q.slot_index[SW-1:0];
	assign rd_ok  = ({1'b0, item_q.slot_index} < 7'(N)) && valid_q[rd_idx];

	// result forming
	pta_pkg::out_item_t res_nx;
	always_comb begin
		res_nx = '0;
		res_nx.peer_count = 7'(count_q);
		case (item_q.req_type)
			pta_pkg::REQ_BEACON: begin
				if (!frame_ok) res_nx.status = pta_pkg::ST_BAD;
				else if (!not_own) res_nx.status = pta_pkg::ST_OWN;
				else begin
					res_nx.status = bstat;
					res_nx.slot   = 6'(tgt);
				end
			end
			pta_pkg::REQ_TICK: begin
				res_nx.status        = pta_pkg::ST_TICK;
				res_nx.send_beacon   = send_q;
				res_nx.expired_count = 7'($countones(expire_q));
			end
			pta_pkg::REQ_READ: begin
				res_nx.status = pta_pkg::ST_READ;
				res_nx.slot   = item_q.slot_index;
				if (rd_ok) begin
					res_nx.entry_valid = 1'b1;
					res_nx.entry_mac   = mac_q[rd_idx];
					res_nx.entry_ip    = ip_q[rd_idx];
					res_nx.entry_age   = item_q.now_ms - seen_q[rd_idx];
				end
			end
			default: res_nx.status = pta_pkg::ST_BAD;
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) out_item <= res_nx;
	end

endmodule
`default_nettype wire

// ----- src/peer_table_with_aging.sv -----
// ----------------------------------------------------------------------------
// peer_table_with_aging: learned peer table with TTL aging and LRU eviction
//
// Input channel (in_valid/in_ready/in_item) takes beacon, tick or read items;
// output channel (out_valid/out_ready/out_item) gives one result beat per item.
// The cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the five
// registers; cfg_ready is always high. The user makes writes only while idle;
// the block does not enforce this. From the accepting edge to the edge that
// raises out_valid, beacons that pass checks and ticks go through the serial
// slot scan, an update step and an output load. Bad/own beacons, reads and
// unknown requests go through a decode step and an output load.
// The next item is accepted the cycle after the result is loaded; a new item
// is not taken before the previous one is through. A finished result may
// wait in the output register while a new item runs.
// The slot scan through the one comparator sets the rate.
// Reset clears all slots' valid bits, the counters and the configuration registers at once.
// If the receiver stalls, a finished item waits in the output state until
// the output register frees; in_ready stays low meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none
module peer_table_with_aging (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire pta_pkg::in_item_t  in_item,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output pta_pkg::out_item_t      out_item,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data
);

	pta_pkg::dp_cmd_t cmd;
	pta_pkg::dp_sts_t sts;

	assign cfg_ready = 1'b1;

	pta_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .sts(sts)
	);

	pta_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_valid(cfg_valid), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_item(in_item), .cmd(cmd), .sts(sts),
		.out_item(out_item)
	);

	// one command at a time
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.scan, cmd.commit, cmd.out_load}))
		else $error("controller issued overlapping commands");

	// acceptance only with no scan in flight
	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> in_ready)
		else $error("item captured while busy");

	// result raises valid next cycle
	a_out_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid)
		else $error("result loaded without valid");

endmodule
`default_nettype wire
